// ===== rtl/npra_pkg.sv =====
`timescale 1ns / 1ps

package npra_pkg;

    // Table geometry
    localparam int MAX_POINTS    = 64;
    localparam int MAX_ROW_WORDS = 32;
    localparam int MAX_KEYS      = 4;

    // Field widths
    localparam int ELEM_W   = 16;
    localparam int SLOT_W   = 6;
    localparam int PCOUNT_W = 7;

    // Configuration register widths
    localparam int KDIM_W = 3;
    localparam int RWRD_W = 6;
    localparam int THR_W  = 32;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 2;

    // Derived widths
    localparam int ROW_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int WORD_W  = $clog2(MAX_ROW_WORDS);
    localparam int WCNT_W  = $clog2(MAX_ROW_WORDS + 1);
    localparam int KEY_W   = $clog2(MAX_KEYS);
    localparam int TBL_D   = MAX_POINTS * MAX_ROW_WORDS;
    localparam int TBL_AW  = $clog2(TBL_D);
    localparam int SQ_W    = 2 * ELEM_W;
    localparam int DIST_W  = SQ_W + KEY_W;

    // Rows at this squared distance or beyond are never chosen (100.0^2 in Q16.16)
    localparam logic [DIST_W-1:0] FAR_LIMIT_SQ = DIST_W'(64'd10000 << 16);

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_KEY_DIMS  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_ROW_WORDS = 2'd1;
    localparam logic [CIDX_W-1:0] REG_NEAR_THR  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_COPY,
        ST_COPY_TAIL,
        ST_FINISH
    } state_t;

    // Tag that travels with each table word through the distance unit
    typedef struct packed {
        logic             first;
        logic             last;
        logic [ROW_W-1:0] row;
    } dist_tag_t;

endpackage

// ===== rtl/nearest_point_replace_or_append_top.sv =====
`timescale 1ns / 1ps

// Words of a point are taken one per cycle; the block is busy from the last word on.
// After the last word: stored_rows * key_dims table reads and a pipeline drain (no scan on
// an empty table), a decide step, a write of the whole row (skipped when the point is
// dropped), then a load of the output register, held while the previous result waits.
// Reset (aresetn, synchronous, active low) empties the table and restores register
// defaults; no clearing pass is run.

module nearest_point_replace_or_append_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_we,
    input  logic [npra_pkg::CIDX_W-1:0]           cfg_index,
    input  logic [npra_pkg::CFG_W-1:0]            cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [npra_pkg::ELEM_W-1:0]    s_elem_value,
    input  logic                                  s_elem_last,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [npra_pkg::SLOT_W-1:0]           m_slot,
    output logic                                  m_replaced,
    output logic                                  m_table_full,
    output logic [npra_pkg::PCOUNT_W-1:0]         m_point_count
);

    // Configuration registers
    logic [npra_pkg::KDIM_W-1:0] key_dims_reg;
    logic [npra_pkg::RWRD_W-1:0] row_words_reg;
    logic [npra_pkg::THR_W-1:0]  near_thr_reg;

    // Sequencer and counters
    npra_pkg::state_t             state_reg, state_next;
    logic [npra_pkg::WCNT_W-1:0]  word_cnt_reg, word_cnt_next;
    logic [npra_pkg::WCNT_W-1:0]  pt_words_reg, pt_words_next;
    logic [npra_pkg::WCNT_W-1:0]  rw_eff_reg, rw_eff_next;
    logic [npra_pkg::KEY_W-1:0]   key_last_reg, key_last_next;
    logic [npra_pkg::CNT_W-1:0]   stored_reg, stored_next;
    logic [npra_pkg::ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [npra_pkg::KEY_W-1:0]   scan_k_reg, scan_k_next;
    logic [npra_pkg::WORD_W-1:0]  cp_w_reg, cp_w_next;

    // Key words of the incoming point
    logic [npra_pkg::ELEM_W-1:0]  key_reg [npra_pkg::MAX_KEYS];

    // Issue stage aligned with table read data
    logic                         iss_v_reg, iss_v_next;
    npra_pkg::dist_tag_t          iss_tag_reg, iss_tag_next;
    logic [npra_pkg::KEY_W-1:0]   iss_k_reg, iss_k_next;

    // Best-row search
    logic                         found_reg, found_next;
    logic [npra_pkg::DIST_W-1:0]  best_reg, best_next;
    logic [npra_pkg::ROW_W-1:0]   best_row_reg, best_row_next;

    // Decision
    logic [npra_pkg::ROW_W-1:0]   target_reg, target_next;
    logic                         replace_reg, replace_next;
    logic                         full_reg, full_next;
    logic [npra_pkg::WCNT_W-1:0]  used_reg, used_next;

    // Row copy write stage
    logic                         cp_v_reg, cp_v_next;
    logic [npra_pkg::WORD_W-1:0]  cp_wd_reg;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    logic [npra_pkg::SLOT_W-1:0]  slot_reg;
    logic                         replaced_reg;
    logic                         full_out_reg;
    logic [npra_pkg::PCOUNT_W-1:0] count_reg;
    logic                         load_out;

    // Memory ports
    logic                         buf_we;
    logic [npra_pkg::WORD_W-1:0]  buf_waddr, buf_raddr;
    logic [npra_pkg::ELEM_W-1:0]  buf_rdata;
    logic                         tbl_we;
    logic [npra_pkg::TBL_AW-1:0]  tbl_waddr, tbl_raddr;
    logic [npra_pkg::ELEM_W-1:0]  tbl_wdata, tbl_rdata;

    // Distance unit
    logic                         dist_v;
    logic [npra_pkg::ROW_W-1:0]   dist_row;
    logic [npra_pkg::DIST_W-1:0]  dist_val;

    logic                         s_acc;
    logic [npra_pkg::KDIM_W-1:0]  keys_eff;
    logic [npra_pkg::RWRD_W-1:0]  rw_clamp;
    logic                         dist_last_row;

    assign s_ready = (state_reg == npra_pkg::ST_LOAD);
    assign s_acc   = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_dims_reg  <= npra_pkg::KDIM_W'(1);
            row_words_reg <= npra_pkg::RWRD_W'(7);
            near_thr_reg  <= npra_pkg::THR_W'(655);
        end else if (cfg_we) begin
            unique case (cfg_index)
                npra_pkg::REG_KEY_DIMS:  key_dims_reg  <= cfg_data[npra_pkg::KDIM_W-1:0];
                npra_pkg::REG_ROW_WORDS: row_words_reg <= cfg_data[npra_pkg::RWRD_W-1:0];
                npra_pkg::REG_NEAR_THR:  near_thr_reg  <= cfg_data[npra_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp row length and key count
    always_comb begin
        if (row_words_reg < npra_pkg::RWRD_W'(2)) begin
            rw_clamp = npra_pkg::RWRD_W'(2);
        end else if (npra_pkg::WCNT_W'(row_words_reg) > npra_pkg::WCNT_W'(npra_pkg::MAX_ROW_WORDS)) begin
            rw_clamp = npra_pkg::RWRD_W'(npra_pkg::MAX_ROW_WORDS);
        end else begin
            rw_clamp = row_words_reg;
        end
        if (key_dims_reg == '0) begin
            keys_eff = npra_pkg::KDIM_W'(1);
        end else if (key_dims_reg > npra_pkg::KDIM_W'(npra_pkg::MAX_KEYS)) begin
            keys_eff = npra_pkg::KDIM_W'(npra_pkg::MAX_KEYS);
        end else begin
            keys_eff = key_dims_reg;
        end
        if (npra_pkg::RWRD_W'(keys_eff) > rw_clamp) begin
            keys_eff = npra_pkg::KDIM_W'(rw_clamp);
        end
    end

    // Capture key words; the first word of a point clears the rest
    always_ff @(posedge aclk) begin
        for (int j = 0; j < npra_pkg::MAX_KEYS; j++) begin
            if (s_acc) begin
                if (word_cnt_reg == npra_pkg::WCNT_W'(j)) begin
                    key_reg[j] <= s_elem_value;
                end else if (word_cnt_reg == '0) begin
                    key_reg[j] <= '0;
                end
            end
        end
    end

    assign dist_last_row = (npra_pkg::CNT_W'(dist_row) + npra_pkg::CNT_W'(1) == stored_reg);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        word_cnt_next = word_cnt_reg;
        pt_words_next = pt_words_reg;
        rw_eff_next   = rw_eff_reg;
        key_last_next = key_last_reg;
        stored_next   = stored_reg;
        scan_row_next = scan_row_reg;
        scan_k_next   = scan_k_reg;
        cp_w_next     = cp_w_reg;
        iss_v_next    = 1'b0;
        iss_tag_next  = iss_tag_reg;
        iss_k_next    = scan_k_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_row_next = best_row_reg;
        target_next   = target_reg;
        replace_next  = replace_reg;
        full_next     = full_reg;
        used_next     = used_reg;
        cp_v_next     = 1'b0;
        load_out      = 1'b0;
        buf_we        = 1'b0;
        buf_waddr     = word_cnt_reg[npra_pkg::WORD_W-1:0];
        buf_raddr     = cp_w_reg;
        tbl_raddr     = npra_pkg::TBL_AW'(scan_row_reg) * npra_pkg::TBL_AW'(npra_pkg::MAX_ROW_WORDS)
                      + npra_pkg::TBL_AW'(scan_k_reg);

        // Track the nearest candidate as row distances come out
        if (dist_v && dist_val < npra_pkg::FAR_LIMIT_SQ && (!found_reg || dist_val < best_reg)) begin
            found_next    = 1'b1;
            best_next     = dist_val;
            best_row_next = dist_row;
        end

        unique case (state_reg)
            npra_pkg::ST_LOAD: begin
                if (s_acc) begin
                    if (word_cnt_reg < npra_pkg::WCNT_W'(npra_pkg::MAX_ROW_WORDS)) begin
                        buf_we        = 1'b1;
                        word_cnt_next = word_cnt_reg + npra_pkg::WCNT_W'(1);
                    end
                    if (s_elem_last) begin
                        pt_words_next = word_cnt_next;
                        word_cnt_next = '0;
                        rw_eff_next   = npra_pkg::WCNT_W'(rw_clamp);
                        key_last_next = npra_pkg::KEY_W'(keys_eff - npra_pkg::KDIM_W'(1));
                        found_next    = 1'b0;
                        scan_row_next = '0;
                        scan_k_next   = '0;
                        state_next    = (stored_reg == '0) ? npra_pkg::ST_DECIDE
                                                           : npra_pkg::ST_SCAN;
                    end
                end
            end

            // Issue one table read per cycle: rows outer, key words inner
            npra_pkg::ST_SCAN: begin
                iss_v_next         = 1'b1;
                iss_tag_next.row   = scan_row_reg;
                iss_tag_next.first = (scan_k_reg == '0);
                iss_tag_next.last  = (scan_k_reg == key_last_reg);
                if (scan_k_reg == key_last_reg) begin
                    scan_k_next = '0;
                    if (npra_pkg::CNT_W'(scan_row_reg) + npra_pkg::CNT_W'(1) == stored_reg) begin
                        state_next = npra_pkg::ST_DRAIN;
                    end else begin
                        scan_row_next = scan_row_reg + npra_pkg::ROW_W'(1);
                    end
                end else begin
                    scan_k_next = scan_k_reg + npra_pkg::KEY_W'(1);
                end
            end

            // Wait for the last row's distance
            npra_pkg::ST_DRAIN: begin
                if (dist_v && dist_last_row) begin
                    state_next = npra_pkg::ST_DECIDE;
                end
            end

            npra_pkg::ST_DECIDE: begin
                replace_next = found_reg && (best_reg < npra_pkg::DIST_W'(near_thr_reg));
                full_next    = 1'b0;
                used_next    = (pt_words_reg < rw_eff_reg) ? pt_words_reg : rw_eff_reg;
                cp_w_next    = '0;
                if (replace_next) begin
                    target_next = best_row_reg;
                    state_next  = npra_pkg::ST_COPY;
                end else if (stored_reg >= npra_pkg::CNT_W'(npra_pkg::MAX_POINTS)) begin
                    target_next = '0;
                    full_next   = 1'b1;
                    state_next  = npra_pkg::ST_FINISH;
                end else begin
                    target_next = stored_reg[npra_pkg::ROW_W-1:0];
                    stored_next = stored_reg + npra_pkg::CNT_W'(1);
                    state_next  = npra_pkg::ST_COPY;
                end
            end

            // Read buffered words; the write lands in the following cycle
            npra_pkg::ST_COPY: begin
                cp_v_next = 1'b1;
                if (cp_w_reg == npra_pkg::WORD_W'(npra_pkg::MAX_ROW_WORDS - 1)) begin
                    state_next = npra_pkg::ST_COPY_TAIL;
                end else begin
                    cp_w_next = cp_w_reg + npra_pkg::WORD_W'(1);
                end
            end

            npra_pkg::ST_COPY_TAIL: begin
                state_next = npra_pkg::ST_FINISH;
            end

            // Hold until the output register is free
            npra_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = npra_pkg::ST_LOAD;
                end
            end

            default: begin
                state_next = npra_pkg::ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= npra_pkg::ST_LOAD;
            word_cnt_reg <= '0;
            stored_reg   <= '0;
            iss_v_reg    <= 1'b0;
            cp_v_reg     <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            word_cnt_reg <= word_cnt_next;
            stored_reg   <= stored_next;
            iss_v_reg    <= iss_v_next;
            cp_v_reg     <= cp_v_next;
            found_reg    <= found_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        pt_words_reg <= pt_words_next;
        rw_eff_reg   <= rw_eff_next;
        key_last_reg <= key_last_next;
        scan_row_reg <= scan_row_next;
        scan_k_reg   <= scan_k_next;
        cp_w_reg     <= cp_w_next;
        iss_tag_reg  <= iss_tag_next;
        iss_k_reg    <= iss_k_next;
        best_reg     <= best_next;
        best_row_reg <= best_row_next;
        target_reg   <= target_next;
        replace_reg  <= replace_next;
        full_reg     <= full_next;
        used_reg     <= used_next;
        cp_wd_reg    <= cp_w_reg;
    end

    // Table write from the copy stage; words past the used length become zero
    assign tbl_we    = cp_v_reg;
    assign tbl_waddr = npra_pkg::TBL_AW'(target_reg) * npra_pkg::TBL_AW'(npra_pkg::MAX_ROW_WORDS)
                     + npra_pkg::TBL_AW'(cp_wd_reg);
    assign tbl_wdata = (npra_pkg::WCNT_W'(cp_wd_reg) < used_reg) ? buf_rdata : '0;

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            slot_reg     <= full_reg ? '0 : npra_pkg::SLOT_W'(target_reg);
            replaced_reg <= replace_reg;
            full_out_reg <= full_reg;
            count_reg    <= npra_pkg::PCOUNT_W'(stored_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_slot        = slot_reg;
    assign m_replaced    = replaced_reg;
    assign m_table_full  = full_out_reg;
    assign m_point_count = count_reg;

    // Incoming point buffer
    npra_ram #(
        .DEPTH (npra_pkg::MAX_ROW_WORDS),
        .WIDTH (npra_pkg::ELEM_W)
    ) u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (s_elem_value),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // Point table
    npra_ram #(
        .DEPTH (npra_pkg::TBL_D),
        .WIDTH (npra_pkg::ELEM_W)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Shared subtract-square-accumulate unit
    npra_dist_unit u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (iss_v_reg),
        .in_tag    (iss_tag_reg),
        .key_word  (key_reg[iss_k_reg]),
        .row_word  (tbl_rdata),
        .out_valid (dist_v),
        .out_row   (dist_row),
        .out_dist  (dist_val)
    );

endmodule

// ===== rtl/npra_ram.sv =====
`timescale 1ns / 1ps

module npra_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/npra_dist_unit.sv =====
`timescale 1ns / 1ps

module npra_dist_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    input  npra_pkg::dist_tag_t                    in_tag,
    input  logic signed [npra_pkg::ELEM_W-1:0]     key_word,
    input  logic signed [npra_pkg::ELEM_W-1:0]     row_word,
    output logic                                   out_valid,
    output logic [npra_pkg::ROW_W-1:0]             out_row,
    output logic [npra_pkg::DIST_W-1:0]            out_dist
);

    logic signed [npra_pkg::ELEM_W:0]    diff;
    logic [npra_pkg::ELEM_W:0]           diff_abs;
    logic [npra_pkg::ELEM_W-1:0]         mag;

    logic                                sq_v_reg;
    npra_pkg::dist_tag_t                 sq_tag_reg;
    logic [npra_pkg::SQ_W-1:0]           sq_reg;

    logic                                acc_v_reg;
    logic [npra_pkg::ROW_W-1:0]          acc_row_reg;
    logic [npra_pkg::DIST_W-1:0]         acc_reg;
    logic [npra_pkg::DIST_W-1:0]         acc_next;

    // Difference and magnitude of one key word
    always_comb begin
        diff     = {key_word[npra_pkg::ELEM_W-1], key_word}
                 - {row_word[npra_pkg::ELEM_W-1], row_word};
        diff_abs = diff[npra_pkg::ELEM_W] ? 17'(-diff) : 17'(diff);
        mag      = diff_abs[npra_pkg::ELEM_W-1:0];
    end

    // Square stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg <= 1'b0;
        end else begin
            sq_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        sq_tag_reg <= in_tag;
        sq_reg     <= mag * mag;
    end

    // Accumulate over the key words of one row
    assign acc_next = (sq_tag_reg.first ? '0 : acc_reg)
                    + npra_pkg::DIST_W'(sq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_v_reg <= 1'b0;
        end else begin
            acc_v_reg <= sq_v_reg && sq_tag_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_v_reg) begin
            acc_reg     <= acc_next;
            acc_row_reg <= sq_tag_reg.row;
        end
    end

    assign out_valid = acc_v_reg;
    assign out_row   = acc_row_reg;
    assign out_dist  = acc_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // Longest busy stretch of the block: full scan, decide, row write, output load
    localparam int IDLE_WAIT         = npra_pkg::MAX_POINTS * npra_pkg::MAX_KEYS
                                     + npra_pkg::MAX_ROW_WORDS + 16;
    localparam int ITEMS_PER_PHASE   = 480;
    localparam int ITEMS_PER_SETTING = 120;
    localparam logic [npra_pkg::CIDX_W-1:0] REG_SPARE = 2'd3;
    // 100.0^2 in Q16.16; rows at or beyond this are never candidates
    localparam longint FAR_SQ = 64'd10000 << 16;

    typedef struct packed {
        logic [npra_pkg::SLOT_W-1:0]   slot;
        logic                          replaced;
        logic                          table_full;
        logic [npra_pkg::PCOUNT_W-1:0] point_count;
    } insert_result_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_we;
    logic [npra_pkg::CIDX_W-1:0]       cfg_index;
    logic [npra_pkg::CFG_W-1:0]        cfg_data;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [npra_pkg::ELEM_W-1:0] s_elem_value;
    logic                              s_elem_last;
    logic                              m_valid;
    logic                              m_ready;
    logic [npra_pkg::SLOT_W-1:0]       m_slot;
    logic                              m_replaced;
    logic                              m_table_full;
    logic [npra_pkg::PCOUNT_W-1:0]     m_point_count;

    // Shadow of the table, the partial point and the registers
    insert_result_t              expected_inserts[$];
    logic [npra_pkg::ELEM_W-1:0] shadow_table [npra_pkg::MAX_POINTS][npra_pkg::MAX_ROW_WORDS];
    int                          shadow_rows;
    logic [npra_pkg::ELEM_W-1:0] point_words [npra_pkg::MAX_ROW_WORDS];
    int                          words_taken;
    logic [npra_pkg::KDIM_W-1:0] key_dims_reg;
    logic [npra_pkg::RWRD_W-1:0] row_words_reg;
    logic [npra_pkg::THR_W-1:0]  near_thr_reg;

    int sender_idle_pct;
    int recv_idle_pct;
    int words_sent;
    int errors;

    nearest_point_replace_or_append_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_elem_value  (s_elem_value),
        .s_elem_last   (s_elem_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_replaced    (m_replaced),
        .m_table_full  (m_table_full),
        .m_point_count (m_point_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_row_words();
        int rw;
        rw = int'(row_words_reg);
        if (rw < 2) rw = 2;
        if (rw > npra_pkg::MAX_ROW_WORDS) rw = npra_pkg::MAX_ROW_WORDS;
        return rw;
    endfunction

    function automatic longint key_distance(int row, int keys);
        longint sum;
        int     diff;
        int     k;
        sum = 0;
        for (k = 0; k < keys; k++) begin
            diff = int'($signed(point_words[k])) - int'($signed(shadow_table[row][k]));
            sum += longint'(diff) * longint'(diff);
        end
        return sum;
    endfunction

    // Buffer one word; on the last word pick the target row and queue the result
    function automatic void absorb_word(logic [npra_pkg::ELEM_W-1:0] value, logic last);
        int             rw, keys, target, used, r, w, best_row;
        bit             found, replace, full;
        longint         best, d;
        insert_result_t res;
        if (words_taken < npra_pkg::MAX_ROW_WORDS) begin
            point_words[words_taken] = value;
            words_taken++;
        end
        if (!last) return;

        rw = clamp_row_words();
        keys = int'(key_dims_reg);
        if (keys < 1) keys = 1;
        if (keys > npra_pkg::MAX_KEYS) keys = npra_pkg::MAX_KEYS;
        if (keys > rw) keys = rw;

        // Nearest candidate row, lowest index on ties
        found = 1'b0;
        best = 0;
        best_row = 0;
        for (r = 0; r < shadow_rows; r++) begin
            d = key_distance(r, keys);
            if (d < FAR_SQ && (!found || d < best)) begin
                found = 1'b1;
                best = d;
                best_row = r;
            end
        end
        replace = found && (best < longint'({32'd0, near_thr_reg}));
        full = 1'b0;
        target = 0;
        if (replace) begin
            target = best_row;
        end else if (shadow_rows >= npra_pkg::MAX_POINTS) begin
            full = 1'b1;
        end else begin
            target = shadow_rows;
            shadow_rows++;
        end

        if (!full) begin
            used = (words_taken < rw) ? words_taken : rw;
            for (w = 0; w < npra_pkg::MAX_ROW_WORDS; w++)
                shadow_table[target][w] = (w < used) ? point_words[w] : '0;
        end
        for (w = 0; w < npra_pkg::MAX_ROW_WORDS; w++)
            point_words[w] = '0;
        words_taken = 0;

        res.slot        = full ? '0 : npra_pkg::SLOT_W'(target);
        res.replaced    = replace;
        res.table_full  = full;
        res.point_count = npra_pkg::PCOUNT_W'(shadow_rows);
        expected_inserts.push_back(res);
    endfunction

    // Present one item, with a random gap first, and hold it until accepted
    task automatic send_word(input logic [npra_pkg::ELEM_W-1:0] value, input logic last);
        bit lowered;
        lowered = 1'b0;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            if (!lowered) s_valid <= 1'b0;
            lowered = 1'b1;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_elem_value <= value;
        s_elem_last  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_word(value, last);
        words_sent++;
    endtask

    task automatic send_words(input int count, input logic [npra_pkg::ELEM_W-1:0] first,
                              input logic [npra_pkg::ELEM_W-1:0] second,
                              input logic [npra_pkg::ELEM_W-1:0] third);
        if (count >= 1) send_word(first, count == 1);
        if (count >= 2) send_word(second, count == 2);
        if (count >= 3) send_word(third, 1'b1);
    endtask

    // Hold the input until every result is back and the block has settled
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_inserts.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [npra_pkg::CIDX_W-1:0] index,
                             input logic [npra_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        case (index)
            npra_pkg::REG_KEY_DIMS:  key_dims_reg  = value[npra_pkg::KDIM_W-1:0];
            npra_pkg::REG_ROW_WORDS: row_words_reg = value[npra_pkg::RWRD_W-1:0];
            npra_pkg::REG_NEAR_THR:  near_thr_reg  = value[npra_pkg::THR_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Empty table append, replace just under the default limit, append just over it
    task automatic test_reset_defaults();
        send_words(2, 16'h7FFF, 16'h0001, 16'h0000);
        send_words(1, 16'h7FE6, 16'h0000, 16'h0000);
        send_words(1, 16'h7FC0, 16'h0000, 16'h0000);
    endtask

    // Far rows are skipped even with the largest limit; exact far boundary appends
    task automatic test_far_rows();
        wait_drained();
        write_reg(npra_pkg::REG_NEAR_THR, 32'hFFFF_FFFF);
        send_words(1, 16'h8000, 16'h0000, 16'h0000);
        send_words(1, 16'hE400, 16'h0000, 16'h0000);
        send_words(1, 16'hE3FF, 16'h0000, 16'h0000);
    endtask

    // Zero limit forces duplicate rows; a tie then goes to the lower row
    task automatic test_nearest_tie();
        wait_drained();
        write_reg(npra_pkg::REG_NEAR_THR, 32'd0);
        send_words(2, 16'h1234, 16'h5555, 16'h0000);
        send_words(2, 16'h1234, 16'h5555, 16'h0000);
        wait_drained();
        write_reg(npra_pkg::REG_NEAR_THR, 32'd100);
        send_words(1, 16'h1234, 16'h0000, 16'h0000);
    endtask

    // Out of range register values and key width limited by row width
    task automatic test_register_clamp();
        wait_drained();
        write_reg(npra_pkg::REG_KEY_DIMS, 32'd0);
        write_reg(npra_pkg::REG_ROW_WORDS, 32'd1);
        send_words(3, 16'h0000, 16'hFFFF, 16'h00FF);
        wait_drained();
        write_reg(npra_pkg::REG_KEY_DIMS, 32'd7);
        write_reg(npra_pkg::REG_ROW_WORDS, 32'd63);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_words(1, 16'h0001, 16'h0000, 16'h0000);
        wait_drained();
        write_reg(npra_pkg::REG_KEY_DIMS, 32'd4);
        write_reg(npra_pkg::REG_ROW_WORDS, 32'd2);
        send_words(3, 16'h0001, 16'h0000, 16'h7FFF);
        wait_drained();
        write_reg(npra_pkg::REG_KEY_DIMS, 32'd5);
        write_reg(npra_pkg::REG_ROW_WORDS, 32'd0);
        send_words(1, 16'h4000, 16'h0000, 16'h0000);
    endtask

    // One point: mostly near or on a stored key, otherwise extreme or random
    task automatic send_random_point();
        int                          len, rw, r, k, i, pick, v, delta;
        logic [npra_pkg::ELEM_W-1:0] key_word [npra_pkg::MAX_KEYS];
        rw = clamp_row_words();
        pick = $urandom_range(0, 99);
        if (pick < 70)      len = rw;
        else if (pick < 85) len = $urandom_range(1, rw);
        else if (pick < 95) len = rw + $urandom_range(1, 4);
        else                len = $urandom_range(npra_pkg::MAX_ROW_WORDS - 2,
                                                 npra_pkg::MAX_ROW_WORDS + 8);

        pick = $urandom_range(0, 99);
        r = (shadow_rows > 0) ? $urandom_range(0, shadow_rows - 1) : 0;
        for (k = 0; k < npra_pkg::MAX_KEYS; k++) begin
            if (shadow_rows > 0 && pick < 45) begin
                delta = $urandom_range(0, 64);
                v = int'($signed(shadow_table[r][k])) + delta - 32;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                key_word[k] = npra_pkg::ELEM_W'(v);
            end else if (shadow_rows > 0 && pick < 55) begin
                key_word[k] = shadow_table[r][k];
            end else if (pick < 65) begin
                key_word[k] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end else begin
                key_word[k] = npra_pkg::ELEM_W'($urandom());
            end
        end
        for (i = 0; i < len; i++)
            send_word((i < npra_pkg::MAX_KEYS) ? key_word[i] : npra_pkg::ELEM_W'($urandom()),
                      i == len - 1);
    endtask

    // Random points under a series of random register settings
    task automatic test_random_traffic(input int sender_pct, input int recv_pct);
        int                         phase_start, setting_start, pick;
        logic [npra_pkg::CFG_W-1:0] thr;
        phase_start = words_sent;
        while (words_sent - phase_start < ITEMS_PER_PHASE) begin
            wait_drained();
            sender_idle_pct = sender_pct;
            recv_idle_pct   = recv_pct;
            pick = $urandom_range(0, 99);
            write_reg(npra_pkg::REG_KEY_DIMS,
                      (pick < 80) ? $urandom_range(1, 4) : $urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                write_reg(npra_pkg::REG_ROW_WORDS, $urandom_range(2, 10));
            else if (pick < 85)
                write_reg(npra_pkg::REG_ROW_WORDS, $urandom_range(11, 32));
            else
                write_reg(npra_pkg::REG_ROW_WORDS,
                          $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(33, 63));
            case ($urandom_range(0, 4))
                0:       thr = 32'd0;
                1:       thr = 32'd655;
                2:       thr = $urandom_range(0, 32'h000F_FFFF);
                3:       thr = 32'hFFFF_FFFF;
                default: thr = $urandom();
            endcase
            write_reg(npra_pkg::REG_NEAR_THR, thr);
            setting_start = words_sent;
            while (words_sent - setting_start < ITEMS_PER_SETTING &&
                   words_sent - phase_start < ITEMS_PER_PHASE)
                send_random_point();
        end
    endtask

    // Result side stalls
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        insert_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_inserts.size() == 0) begin
                $error("result with none expected: slot %0d count %0d", m_slot, m_point_count);
                errors++;
            end else begin
                want = expected_inserts.pop_front();
                if (m_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_slot);
                    errors++;
                end
                if (m_replaced !== want.replaced) begin
                    $error("replaced: expected %0d, got %0d", want.replaced, m_replaced);
                    errors++;
                end
                if (m_table_full !== want.table_full) begin
                    $error("table_full: expected %0d, got %0d", want.table_full, m_table_full);
                    errors++;
                end
                if (m_point_count !== want.point_count) begin
                    $error("point_count: expected %0d, got %0d",
                           want.point_count, m_point_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        int r, w;
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_elem_value <= '0;
        s_elem_last  <= 1'b0;
        for (r = 0; r < npra_pkg::MAX_POINTS; r++)
            for (w = 0; w < npra_pkg::MAX_ROW_WORDS; w++)
                shadow_table[r][w] = '0;
        for (w = 0; w < npra_pkg::MAX_ROW_WORDS; w++)
            point_words[w] = '0;
        shadow_rows     = 0;
        words_taken     = 0;
        key_dims_reg    = 3'd1;
        row_words_reg   = 6'd7;
        near_thr_reg    = 32'd655;
        words_sent      = 0;
        errors          = 0;
        sender_idle_pct = 34;
        recv_idle_pct   = 80;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_far_rows();
        test_nearest_tie();
        test_register_clamp();
        test_random_traffic(34, 80);
        test_random_traffic(80, 34);
        test_random_traffic(0, 0);
        wait_drained();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop for a hung handshake
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
